/* hdl/script_var_flag_unit_assert.svh */
`ifndef SCRIPT_VAR_FLAG_UNIT_ASSERT_SVH
`define SCRIPT_VAR_FLAG_UNIT_ASSERT_SVH

// same-cycle implication, checked on every rising clk edge outside reset
`define SVF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SVF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/svf_pkg.sv */
package svf_pkg;

  localparam int NUM_VARS       = 256;
  localparam int NUM_FLAG_BYTES = 32;
  localparam int NUM_FLAGS      = NUM_FLAG_BYTES * 8;
  localparam int VAR_AW         = $clog2(NUM_VARS);
  localparam int FLAG_AW        = $clog2(NUM_FLAGS);
  localparam int SWEEP_LEN      = (NUM_VARS > NUM_FLAGS) ? NUM_VARS : NUM_FLAGS;
  localparam int SWEEP_AW       = $clog2(SWEEP_LEN);

  // flags raised during a restart sweep
  localparam int RESTART_FLAG_A = 5;
  localparam int RESTART_FLAG_B = 6;

  localparam logic OP_ACTION = 1'b0;
  localparam logic OP_TEST   = 1'b1;

  // action opcodes
  localparam logic [7:0] ACT_INC         = 8'h01;
  localparam logic [7:0] ACT_DEC         = 8'h02;
  localparam logic [7:0] ACT_ASSIGN_IMM  = 8'h03;
  localparam logic [7:0] ACT_ASSIGN_VAR  = 8'h04;
  localparam logic [7:0] ACT_ADD_IMM     = 8'h05;
  localparam logic [7:0] ACT_ADD_VAR     = 8'h06;
  localparam logic [7:0] ACT_SUB_IMM     = 8'h07;
  localparam logic [7:0] ACT_SUB_VAR     = 8'h08;
  localparam logic [7:0] ACT_ASSIGN_IND  = 8'h0B;
  localparam logic [7:0] ACT_SET_FLAG    = 8'h0C;
  localparam logic [7:0] ACT_RESET_FLAG  = 8'h0D;
  localparam logic [7:0] ACT_SET_FLAGV   = 8'h0F;
  localparam logic [7:0] ACT_RESET_FLAGV = 8'h10;
  localparam logic [7:0] ACT_RESTART     = 8'h80;

  // test tokens
  localparam logic [7:0] TST_EQ_IMM     = 8'h01;
  localparam logic [7:0] TST_EQ_VAR     = 8'h02;
  localparam logic [7:0] TST_LT_IMM     = 8'h03;
  localparam logic [7:0] TST_LT_VAR     = 8'h04;
  localparam logic [7:0] TST_GT_IMM     = 8'h05;
  localparam logic [7:0] TST_FLAG       = 8'h07;
  localparam logic [7:0] TST_CONTROLLER = 8'h0C;
  localparam logic [7:0] TST_HAVEKEY    = 8'h0D;
  localparam logic [7:0] TST_OR         = 8'hFC;
  localparam logic [7:0] TST_NOT        = 8'hFD;
  localparam logic [7:0] TST_END        = 8'hFF;

  typedef struct packed {
    logic       op;
    logic [7:0] code;
    logic [7:0] arg_a;
    logic [7:0] arg_b;
    logic       key_waiting;
  } svf_in_t;

  typedef struct packed {
    logic       test_done;
    logic       truth;
    logic       unhandled;
    logic [7:0] value;
  } svf_out_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic sweep;
    logic sweep_set;
  } svf_cmd_t;

  typedef struct packed {
    logic is_restart;
    logic sweep_last;
  } svf_stat_t;

endpackage

/* hdl/svf_ctrl.sv */
module svf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  svf_pkg::svf_stat_t  stat,
  output svf_pkg::svf_cmd_t   cmd
);
  import svf_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_CLEAR = 2'd2;

  logic [1:0] state, state_next;
  logic       restart_mode, restart_mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      restart_mode <= 1'b0;
    end else begin
      state        <= state_next;
      restart_mode <= restart_mode_next;
    end
  end

  always_comb begin
    state_next        = state;
    restart_mode_next = restart_mode;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (stat.is_restart) begin
          state_next        = ST_CLEAR;
          restart_mode_next = 1'b1;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (stat.sweep_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign busy          = (state != ST_IDLE);
  assign cmd.capture   = (state == ST_IDLE) && start;
  assign cmd.exec      = (state == ST_EXEC);
  assign cmd.sweep     = (state == ST_CLEAR);
  assign cmd.sweep_set = restart_mode;

endmodule

/* hdl/svf_dpath.sv */
module svf_dpath (
  input  logic                clk,
  input  logic                rst,
  input  svf_pkg::svf_in_t    item,
  input  svf_pkg::svf_cmd_t   cmd,
  output svf_pkg::svf_stat_t  stat,
  output logic                result_valid,
  output svf_pkg::svf_out_t   result
);
  import svf_pkg::*;

  logic [7:0] var_mem  [NUM_VARS];
  logic       flag_mem [NUM_FLAGS];

  svf_in_t    item_q;
  logic [7:0] rd_a, rd_b;
  logic       rd_f;

  logic [SWEEP_AW-1:0] sweep_cnt;

  logic truth_acc, truth_acc_next;
  logic or_open, or_open_next;
  logic or_acc, or_acc_next;
  logic invert_next, invert_next_next;

  logic               var_we;
  logic [VAR_AW-1:0]  var_waddr;
  logic [7:0]         var_wdata;
  logic               flag_we;
  logic [FLAG_AW-1:0] flag_waddr;
  logic               flag_wdata;

  svf_out_t   res_next;
  logic [7:0] nv;
  logic       r;
  logic       is_test;

  // read both operands at accept, data is ready in the execute cycle
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
      rd_a   <= var_mem[item.arg_a[VAR_AW-1:0]];
      rd_b   <= var_mem[item.arg_b[VAR_AW-1:0]];
      rd_f   <= flag_mem[item.arg_a[FLAG_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (var_we) var_mem[var_waddr] <= var_wdata;
    if (flag_we) flag_mem[flag_waddr] <= flag_wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt <= stat.sweep_last ? '0 : sweep_cnt + 1'b1;
    end
  end

  assign stat.sweep_last = (sweep_cnt == SWEEP_AW'(SWEEP_LEN - 1));
  assign stat.is_restart = (item_q.op == OP_ACTION) && (item_q.code == ACT_RESTART);

  always_comb begin
    var_we           = 1'b0;
    var_waddr        = item_q.arg_a[VAR_AW-1:0];
    var_wdata        = 8'd0;
    flag_we          = 1'b0;
    flag_waddr       = item_q.arg_a[FLAG_AW-1:0];
    flag_wdata       = 1'b0;
    nv               = 8'd0;
    r                = 1'b0;
    is_test          = 1'b1;
    res_next         = '0;
    truth_acc_next   = truth_acc;
    or_open_next     = or_open;
    or_acc_next      = or_acc;
    invert_next_next = invert_next;

    if (cmd.sweep) begin
      var_we     = (int'(sweep_cnt) < NUM_VARS);
      var_waddr  = sweep_cnt[VAR_AW-1:0];
      var_wdata  = 8'd0;
      flag_we    = (int'(sweep_cnt) < NUM_FLAGS);
      flag_waddr = sweep_cnt[FLAG_AW-1:0];
      flag_wdata = cmd.sweep_set &&
                   (sweep_cnt == SWEEP_AW'(RESTART_FLAG_A) ||
                    sweep_cnt == SWEEP_AW'(RESTART_FLAG_B));
    end else if (cmd.exec) begin
      if (item_q.op == OP_ACTION) begin
        unique case (item_q.code)
          ACT_INC:        nv = (rd_a == 8'hFF) ? rd_a : rd_a + 8'd1;
          ACT_DEC:        nv = (rd_a == 8'h00) ? rd_a : rd_a - 8'd1;
          ACT_ASSIGN_IMM: nv = item_q.arg_b;
          ACT_ASSIGN_VAR: nv = rd_b;
          ACT_ADD_IMM:    nv = rd_a + item_q.arg_b;
          ACT_ADD_VAR:    nv = rd_a + rd_b;
          ACT_SUB_IMM:    nv = rd_a - item_q.arg_b;
          ACT_SUB_VAR:    nv = rd_a - rd_b;
          ACT_ASSIGN_IND: begin
            nv        = item_q.arg_b;
            var_waddr = rd_a[VAR_AW-1:0];
          end
          default:        nv = 8'd0;
        endcase
        unique case (item_q.code)
          ACT_INC, ACT_DEC, ACT_ASSIGN_IMM, ACT_ASSIGN_VAR, ACT_ADD_IMM,
          ACT_ADD_VAR, ACT_SUB_IMM, ACT_SUB_VAR, ACT_ASSIGN_IND: begin
            var_we         = 1'b1;
            var_wdata      = nv;
            res_next.value = nv;
          end
          ACT_SET_FLAG, ACT_RESET_FLAG: begin
            flag_we    = 1'b1;
            flag_wdata = (item_q.code == ACT_SET_FLAG);
          end
          ACT_SET_FLAGV, ACT_RESET_FLAGV: begin
            flag_we    = 1'b1;
            flag_waddr = rd_a[FLAG_AW-1:0];
            flag_wdata = (item_q.code == ACT_SET_FLAGV);
          end
          ACT_RESTART: ;
          default: res_next.unhandled = 1'b1;
        endcase
      end else begin
        unique case (item_q.code)
          TST_EQ_IMM:     r = (rd_a == item_q.arg_b);
          TST_EQ_VAR:     r = (rd_a == rd_b);
          TST_LT_IMM:     r = (rd_a < item_q.arg_b);
          TST_LT_VAR:     r = (rd_a < rd_b);
          TST_GT_IMM:     r = (rd_a > item_q.arg_b);
          TST_FLAG:       r = rd_f;
          TST_CONTROLLER: r = 1'b0;
          TST_HAVEKEY:    r = item_q.key_waiting;
          TST_OR: begin
            is_test = 1'b0;
            if (or_open) begin
              or_open_next   = 1'b0;
              truth_acc_next = truth_acc & or_acc;
            end else begin
              or_open_next = 1'b1;
              or_acc_next  = 1'b0;
            end
            invert_next_next = 1'b0;
          end
          TST_NOT: begin
            is_test          = 1'b0;
            invert_next_next = 1'b1;
          end
          TST_END: begin
            is_test            = 1'b0;
            res_next.test_done = 1'b1;
            res_next.truth     = truth_acc;
            truth_acc_next     = 1'b1;
            or_open_next       = 1'b0;
            or_acc_next        = 1'b0;
            invert_next_next   = 1'b0;
          end
          default: begin
            is_test            = 1'b0;
            res_next.unhandled = 1'b1;
          end
        endcase
        if (is_test) begin
          // an open or bracket collects, otherwise and into the condition
          if (or_open) or_acc_next = or_acc | (r ^ invert_next);
          else truth_acc_next = truth_acc & (r ^ invert_next);
          invert_next_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      truth_acc   <= 1'b1;
      or_open     <= 1'b0;
      or_acc      <= 1'b0;
      invert_next <= 1'b0;
    end else if (cmd.exec) begin
      truth_acc   <= truth_acc_next;
      or_open     <= or_open_next;
      or_acc      <= or_acc_next;
      invert_next <= invert_next_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= cmd.exec;
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) result <= res_next;
  end

endmodule

/* hdl/script_var_flag_unit.sv */
// Variable and flag unit for script bytecode: an item is taken at a clock edge with start high
// and busy low, the variable file is read at that edge and the item executes in the next cycle;
// busy stays high while it executes, so a new item is taken only after that; the result beat sits on
// result for exactly one cycle with result_valid high, in the cycle after execution, and the
// receiver cannot stall it. After reset and after a restart action the unit sweeps its 256-entry
// variable and flag memories, one entry a cycle, keeping busy high until the sweep ends.
module script_var_flag_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  svf_pkg::svf_in_t  item,
  output logic              result_valid,
  output svf_pkg::svf_out_t result
);
  import svf_pkg::*;

  svf_cmd_t  cmd;
  svf_stat_t stat;

  svf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  svf_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result       (result)
  );

`include "script_var_flag_unit_assert.svh"

  `SVF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `SVF_ASSERT_NEXT(a_accept_result, start && !busy, ##1 result_valid, "accepted beat gave no result")
  `SVF_ASSERT_NEXT(a_result_single, result_valid, !result_valid, "result strobe held too long")
  `SVF_ASSERT_NOW(a_done_clean, result_valid && result.test_done,
                  !result.unhandled && result.value == 8'd0, "end token result not clean")

endmodule
